// ===== rtl/biles_pkg.sv =====
// Shared types and constants for the expression stack block.
// No dependencies; biles_muldiv and the top level refer to this package by scoped names.
`default_nettype none

package biles_pkg;

    // Operation codes
    localparam logic [3:0] FN_PUSH  = 4'd0;
    localparam logic [3:0] FN_ADD   = 4'd1;
    localparam logic [3:0] FN_SUB   = 4'd2;
    localparam logic [3:0] FN_NEG   = 4'd3;
    localparam logic [3:0] FN_MUL   = 4'd4;
    localparam logic [3:0] FN_DIV   = 4'd5;
    localparam logic [3:0] FN_STORE = 4'd6;
    localparam logic [3:0] FN_INDEX = 4'd7;
    localparam logic [3:0] FN_CMP   = 4'd8;
    localparam logic [3:0] FN_POP   = 4'd9;
    localparam logic [3:0] FN_CLRS  = 4'd10;
    localparam logic [3:0] FN_CLRV  = 4'd11;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_UNDER  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_DIVZ   = 3'd3;
    localparam logic [2:0] ST_BADREL = 3'd4;
    localparam logic [2:0] ST_BADIDX = 3'd5;

    // Relation codes of compare
    localparam logic [31:0] REL_EQ = 32'd0;
    localparam logic [31:0] REL_LT = 32'd1;
    localparam logic [31:0] REL_LE = 32'd2;
    localparam logic [31:0] REL_NE = 32'd3;
    localparam logic [31:0] REL_GT = 32'd4;
    localparam logic [31:0] REL_GE = 32'd5;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic               cond_true;
        logic [2:0]         status;
    } rsp_t;

    // Request into the iterative multiply/divide unit
    typedef struct packed {
        logic        start;
        logic        is_div;
        logic [31:0] lhs;
        logic [31:0] rhs;
    } md_req_t;

    // Stack entries an operation consumes
    function automatic logic [1:0] need_of(input logic [3:0] func);
        logic [1:0] n;
        case (func)
            FN_NEG, FN_INDEX, FN_POP:                  n = 2'd1;
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_STORE:  n = 2'd2;
            FN_CMP:                                    n = 2'd3;
            default:                                   n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/biles_stack_mem.sv =====
// Evaluation stack storage: one write port, one read port, registered read data.
// Depends on nothing; contents are undefined until written.
`default_nettype none

module biles_stack_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/biles_var_mem.sv =====
// Variable store: synchronous memory with per-entry valid bits so that
// reset and clear-variables read back as zero at once. No dependencies.
`default_nettype none

module biles_var_mem #(
    parameter int NUM_VARS = 26,
    parameter int AW       = 5
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic          clr,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rdata
);

    logic [31:0]         mem [NUM_VARS];
    logic [NUM_VARS-1:0] valid_reg;
    logic [31:0]         rdata_reg;
    logic                rvalid_reg;

    // Data array
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // Valid bits: a clear drops them all, a write sets one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (clr)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    // Entries never written since the last clear read as zero
    assign rdata = rvalid_reg ? rdata_reg : 32'd0;

endmodule

`default_nettype wire

// ===== rtl/biles_muldiv.sv =====
// Iterative 32-bit multiply (low word) and signed divide, one bit per cycle.
// Depends on biles_pkg for the request struct.
`default_nettype none

module biles_muldiv (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire biles_pkg::md_req_t req,
    output logic                  done,
    output logic [31:0]           result
);

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_RUN  = 2'd1;
    localparam logic [1:0] MD_FIX  = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        div_reg, div_next;
    logic        neg_reg, neg_next;
    logic [31:0] x_reg, x_next;     // multiplicand / dividend-quotient shifter
    logic [31:0] y_reg, y_next;     // multiplier / divisor
    logic [31:0] acc_reg, acc_next; // product / remainder
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;

    logic [32:0] shifted;
    logic [32:0] trial;
    logic [31:0] lhs_mag;
    logic [31:0] rhs_mag;

    assign lhs_mag = req.lhs[31] ? (32'd0 - req.lhs) : req.lhs;
    assign rhs_mag = req.rhs[31] ? (32'd0 - req.rhs) : req.rhs;
    assign shifted = {acc_reg, x_reg[31]};
    assign trial   = shifted - {1'b0, y_reg};

    // Step logic
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        neg_next   = neg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    div_next   = req.is_div;
                    neg_next   = req.lhs[31] ^ req.rhs[31];
                    x_next     = req.is_div ? lhs_mag : req.lhs;
                    y_next     = req.is_div ? rhs_mag : req.rhs;
                    acc_next   = 32'd0;
                    cnt_next   = 5'd0;
                    state_next = MD_RUN;
                end
            end
            MD_RUN:
            begin
                if (div_reg)
                begin
                    // restoring division step
                    if (!trial[32])
                    begin
                        acc_next = trial[31:0];
                        x_next   = {x_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = shifted[31:0];
                        x_next   = {x_reg[30:0], 1'b0};
                    end
                end
                else
                begin
                    // shift-add multiply step
                    if (y_reg[0])
                    begin
                        acc_next = acc_reg + x_reg;
                    end
                    x_next = {x_reg[30:0], 1'b0};
                    y_next = {1'b0, y_reg[31:1]};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = MD_FIX;
                end
            end
            MD_FIX:
            begin
                if (div_reg)
                begin
                    res_next = neg_reg ? (32'd0 - x_reg) : x_reg;
                end
                else
                begin
                    res_next = acc_reg;
                end
                done_next  = 1'b1;
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

    // Checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == MD_IDLE)
        else $error("muldiv started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("muldiv done longer than one cycle");
    a_done_after_fix: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(state_reg) == MD_FIX)
        else $error("muldiv done without final step");

endmodule

`default_nettype wire

// ===== rtl/basic_il_expression_stack.sv =====
// Top level of the expression stack block: sequencer over the stack and
// variable memories. Depends on biles_pkg, biles_stack_mem, biles_var_mem, biles_muldiv.
`default_nettype none

// One command is worked at a time. After an operand check a command reads the
// top three stack entries through the single read port of the stack memory
// (one entry per cycle, read data registered), does its update, then rereads
// the new top. A last step loads the output register as the sequencer returns
// to idle; index adds a variable read, pop skips the reread and an underflow
// skips the reads and the update. Multiply and divide by a nonzero divisor
// wait on the 32-step shift-add / restoring loop of the shared unit. A result
// that is still stalled in the output register holds the next command in its
// last step until the register frees. The next command is accepted as soon as
// the sequencer is back in idle, even while the previous result still waits in
// the output register. All memory writes complete before the following read is
// issued, so no forwarding is needed. Variables reset to zero at once through
// valid bits.
module basic_il_expression_stack #(
    parameter int STACK_DEPTH = 32,
    parameter int NUM_VARS    = 26
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire biles_pkg::cmd_t cmd,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output biles_pkg::rsp_t      rsp
);

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int SIDX_W = $clog2(STACK_DEPTH);
    localparam int VIDX_W = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_RB   = 4'd2;
    localparam logic [3:0] S_RA   = 4'd3;
    localparam logic [3:0] S_EXEC = 4'd4;
    localparam logic [3:0] S_OP   = 4'd5;
    localparam logic [3:0] S_WAIT = 4'd6;
    localparam logic [3:0] S_VAR  = 4'd7;
    localparam logic [3:0] S_TOP  = 4'd8;
    localparam logic [3:0] S_TOPD = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       func_reg, func_next;
    logic [31:0]      val_reg, val_next;
    logic [31:0]      t_reg, t_next;
    logic [31:0]      b_reg, b_next;
    logic [31:0]      a_reg, a_next;
    logic [31:0]      res_reg, res_next;
    logic             cond_reg, cond_next;
    logic [2:0]       status_reg, status_next;
    logic             rsp_valid_reg, rsp_valid_next;
    biles_pkg::rsp_t  rsp_reg, rsp_next;

    logic [CNT_W-1:0] cm1, cm2, cm3;
    logic [1:0]       need;

    logic              stk_we;
    logic [SIDX_W-1:0] stk_waddr;
    logic [31:0]       stk_wdata;
    logic [SIDX_W-1:0] stk_raddr;
    logic [31:0]       stk_rdata;

    logic              var_we;
    logic [VIDX_W-1:0] var_waddr;
    logic              var_clr;
    logic [VIDX_W-1:0] var_raddr;
    logic [31:0]       var_rdata;

    biles_pkg::md_req_t md_req;
    logic               md_done;
    logic [31:0]        md_result;

    logic a_lt_t;
    logic t_lt_a;

    assign cm1    = count_reg - CNT_W'(1);
    assign cm2    = count_reg - CNT_W'(2);
    assign cm3    = count_reg - CNT_W'(3);
    assign need   = biles_pkg::need_of(func_reg);
    assign a_lt_t = $signed(a_reg) < $signed(t_reg);
    assign t_lt_a = $signed(t_reg) < $signed(a_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        func_next      = func_reg;
        val_next       = val_reg;
        t_next         = t_reg;
        b_next         = b_reg;
        a_next         = a_reg;
        res_next       = res_reg;
        cond_next      = cond_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        stk_we         = 1'b0;
        stk_waddr      = cm2[SIDX_W-1:0];
        stk_wdata      = val_reg;
        stk_raddr      = cm1[SIDX_W-1:0];
        var_we         = 1'b0;
        var_waddr      = b_reg[VIDX_W-1:0];
        var_clr        = 1'b0;
        var_raddr      = t_reg[VIDX_W-1:0];
        md_req.start   = 1'b0;
        md_req.is_div  = (func_reg == biles_pkg::FN_DIV);
        md_req.lhs     = b_reg;
        md_req.rhs     = t_reg;

        // output transfer frees the result register
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    func_next   = cmd.func;
                    val_next    = cmd.value;
                    cond_next   = 1'b0;
                    status_next = biles_pkg::ST_OK;
                    state_next  = S_CHK;
                end
            end
            S_CHK:
            begin
                if (count_reg < CNT_W'(need))
                begin
                    status_next = biles_pkg::ST_UNDER;
                    state_next  = S_TOP;
                end
                else
                begin
                    stk_raddr  = cm1[SIDX_W-1:0];
                    state_next = S_RB;
                end
            end
            S_RB:
            begin
                t_next     = stk_rdata;
                stk_raddr  = cm2[SIDX_W-1:0];
                state_next = S_RA;
            end
            S_RA:
            begin
                b_next     = stk_rdata;
                stk_raddr  = cm3[SIDX_W-1:0];
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                a_next     = stk_rdata;
                state_next = S_OP;
            end
            S_OP:
            begin
                state_next = S_TOP;
                case (func_reg)
                    biles_pkg::FN_PUSH:
                    begin
                        if (count_reg >= CNT_W'(STACK_DEPTH))
                        begin
                            status_next = biles_pkg::ST_OVER;
                        end
                        else
                        begin
                            stk_we     = 1'b1;
                            stk_waddr  = count_reg[SIDX_W-1:0];
                            stk_wdata  = val_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    biles_pkg::FN_ADD:
                    begin
                        stk_we     = 1'b1;
                        stk_wdata  = b_reg + t_reg;
                        count_next = cm1;
                    end
                    biles_pkg::FN_SUB:
                    begin
                        stk_we     = 1'b1;
                        stk_wdata  = b_reg - t_reg;
                        count_next = cm1;
                    end
                    biles_pkg::FN_NEG:
                    begin
                        stk_we    = 1'b1;
                        stk_waddr = cm1[SIDX_W-1:0];
                        stk_wdata = 32'd0 - t_reg;
                    end
                    biles_pkg::FN_MUL:
                    begin
                        md_req.start = 1'b1;
                        state_next   = S_WAIT;
                    end
                    biles_pkg::FN_DIV:
                    begin
                        if (t_reg == 32'd0)
                        begin
                            status_next = biles_pkg::ST_DIVZ;
                        end
                        else
                        begin
                            md_req.start = 1'b1;
                            state_next   = S_WAIT;
                        end
                    end
                    biles_pkg::FN_STORE:
                    begin
                        if (b_reg >= 32'(NUM_VARS))
                        begin
                            status_next = biles_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            var_we     = 1'b1;
                            count_next = cm2;
                        end
                    end
                    biles_pkg::FN_INDEX:
                    begin
                        if (t_reg >= 32'(NUM_VARS))
                        begin
                            status_next = biles_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            state_next = S_VAR;
                        end
                    end
                    biles_pkg::FN_CMP:
                    begin
                        // a rel b with b on top; rel sits in the middle entry
                        count_next = cm3;
                        case (b_reg)
                            biles_pkg::REL_EQ: cond_next = (a_reg == t_reg);
                            biles_pkg::REL_LT: cond_next = a_lt_t;
                            biles_pkg::REL_LE: cond_next = !t_lt_a;
                            biles_pkg::REL_NE: cond_next = (a_reg != t_reg);
                            biles_pkg::REL_GT: cond_next = t_lt_a;
                            biles_pkg::REL_GE: cond_next = !a_lt_t;
                            default:
                            begin
                                status_next = biles_pkg::ST_BADREL;
                                count_next  = count_reg;
                            end
                        endcase
                    end
                    biles_pkg::FN_POP:
                    begin
                        res_next   = t_reg;
                        count_next = cm1;
                        state_next = S_DONE;
                    end
                    biles_pkg::FN_CLRS:
                    begin
                        count_next = '0;
                    end
                    biles_pkg::FN_CLRV:
                    begin
                        var_clr = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WAIT:
            begin
                if (md_done)
                begin
                    stk_we     = 1'b1;
                    stk_wdata  = md_result;
                    count_next = cm1;
                    state_next = S_TOP;
                end
            end
            S_VAR:
            begin
                stk_we     = 1'b1;
                stk_waddr  = cm1[SIDX_W-1:0];
                stk_wdata  = var_rdata;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                stk_raddr  = cm1[SIDX_W-1:0];
                state_next = S_TOPD;
            end
            S_TOPD:
            begin
                res_next   = (count_reg == '0) ? 32'd0 : stk_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.top_value = res_reg;
                    rsp_next.cond_true = cond_reg;
                    rsp_next.status    = status_reg;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Operands and result payload
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        val_reg    <= val_next;
        t_reg      <= t_next;
        b_reg      <= b_next;
        a_reg      <= a_next;
        res_reg    <= res_next;
        cond_reg   <= cond_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    biles_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (SIDX_W)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    biles_var_mem #(
        .NUM_VARS (NUM_VARS),
        .AW       (VIDX_W)
    ) u_vars (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (t_reg),
        .clr   (var_clr),
        .raddr (var_raddr),
        .rdata (var_rdata)
    );

    biles_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .done   (md_done),
        .result (md_result)
    );

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stk_we |-> CNT_W'(stk_waddr) <= count_reg)
        else $error("stack write above top");
    a_cond_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.cond_true) |-> rsp_reg.status == biles_pkg::ST_OK)
        else $error("true compare reported with error status");
    a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TOP && status_reg != biles_pkg::ST_OK) |=> $stable(count_reg))
        else $error("stack count moved on an error");

endmodule

`default_nettype wire

// ===== tb/expr_stack_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the expression stack block: keeps its own stack and variable
// store, predicts one response per accepted command and checks them in order.
// Depends on biles_pkg.
module expr_stack_checker #(
    parameter int STACK_DEPTH = 32,
    parameter int NUM_VARS    = 26
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_stall,
    input  biles_pkg::cmd_t  cmd,
    input  logic             rsp_valid,
    input  logic             rsp_stall,
    input  biles_pkg::rsp_t  rsp,
    output int               errors,
    output int               rsp_count
);
    import biles_pkg::*;

    logic [31:0] eval_mirror [STACK_DEPTH];
    logic [31:0] var_mirror [NUM_VARS];
    int unsigned mirror_depth;
    rsp_t        pending_rsps [$];
    rsp_t        want;

    // Execute one command on the mirrored state and return its response
    function automatic rsp_t apply_cmd(cmd_t c);
        rsp_t        r;
        logic [31:0] a, b, t, un, ud, q;
        int unsigned n, need;
        logic        holds;
        logic        popped;
        r = '0;
        popped = 1'b0;
        holds = 1'b0;
        n = mirror_depth;
        t = (n >= 1) ? eval_mirror[n - 1] : '0;
        b = (n >= 2) ? eval_mirror[n - 2] : '0;
        case (c.func)
            FN_NEG, FN_INDEX, FN_POP:                 need = 1;
            FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_STORE: need = 2;
            FN_CMP:                                   need = 3;
            default:                                  need = 0;
        endcase
        // operand count is checked ahead of everything else
        if (n < need)
            r.status = ST_UNDER;
        else
        begin
            case (c.func)
                FN_PUSH:
                    if (n >= STACK_DEPTH)
                        r.status = ST_OVER;
                    else
                    begin
                        eval_mirror[n] = c.value;
                        mirror_depth = n + 1;
                    end
                FN_ADD:
                begin
                    eval_mirror[n - 2] = b + t;
                    mirror_depth = n - 1;
                end
                FN_SUB:
                begin
                    eval_mirror[n - 2] = b - t;
                    mirror_depth = n - 1;
                end
                FN_NEG:
                    eval_mirror[n - 1] = 32'd0 - t;
                FN_MUL:
                begin
                    eval_mirror[n - 2] = b * t;
                    mirror_depth = n - 1;
                end
                FN_DIV:
                    if (t == '0)
                        r.status = ST_DIVZ;
                    else
                    begin
                        // magnitudes, then fix the sign: truncates toward zero
                        un = b[31] ? 32'd0 - b : b;
                        ud = t[31] ? 32'd0 - t : t;
                        q = un / ud;
                        eval_mirror[n - 2] = (b[31] ^ t[31]) ? 32'd0 - q : q;
                        mirror_depth = n - 1;
                    end
                FN_STORE:
                    if (b >= 32'(NUM_VARS))
                        r.status = ST_BADIDX;
                    else
                    begin
                        var_mirror[b] = t;
                        mirror_depth = n - 2;
                    end
                FN_INDEX:
                    if (t >= 32'(NUM_VARS))
                        r.status = ST_BADIDX;
                    else
                        eval_mirror[n - 1] = var_mirror[t];
                FN_CMP:
                begin
                    // a, relation, b with b on top
                    a = eval_mirror[n - 3];
                    case (b)
                        REL_EQ:  holds = (a == t);
                        REL_LT:  holds = ($signed(a) < $signed(t));
                        REL_LE:  holds = ($signed(a) <= $signed(t));
                        REL_NE:  holds = (a != t);
                        REL_GT:  holds = ($signed(a) > $signed(t));
                        REL_GE:  holds = ($signed(a) >= $signed(t));
                        default: r.status = ST_BADREL;
                    endcase
                    if (r.status == ST_OK)
                    begin
                        r.cond_true = holds;
                        mirror_depth = n - 3;
                    end
                end
                FN_POP:
                begin
                    r.top_value = t;
                    popped = 1'b1;
                    mirror_depth = n - 1;
                end
                FN_CLRS:
                    mirror_depth = 0;
                FN_CLRV:
                    foreach (var_mirror[i])
                        var_mirror[i] = '0;
                default:
                    ;
            endcase
        end
        if (!popped)
            r.top_value = (mirror_depth == 0) ? '0 : eval_mirror[mirror_depth - 1];
        return r;
    endfunction

    // Response check first: its expectation always predates a same-edge command
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_depth = 0;
            foreach (eval_mirror[i])
                eval_mirror[i] = '0;
            foreach (var_mirror[i])
                var_mirror[i] = '0;
            pending_rsps.delete();
            errors = 0;
            rsp_count <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsps.size() == 0)
                begin
                    $error("unexpected response transfer: top_value %0d status %0d",
                           rsp.top_value, rsp.status);
                    errors++;
                end
                else
                begin
                    want = pending_rsps.pop_front();
                    if (rsp.top_value !== want.top_value)
                    begin
                        $error("top_value expected %0d got %0d", want.top_value, rsp.top_value);
                        errors++;
                    end
                    if (rsp.cond_true !== want.cond_true)
                    begin
                        $error("cond_true expected %0d got %0d", want.cond_true, rsp.cond_true);
                        errors++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, rsp.status);
                        errors++;
                    end
                end
                rsp_count <= rsp_count + 1;
            end
            if (cmd_valid && !cmd_stall)
                pending_rsps.push_back(apply_cmd(cmd));
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the expression stack regression: clock, reset, command stimulus and
// response back-pressure. Depends on biles_pkg, basic_il_expression_stack, expr_stack_checker.
module testbench;
    import biles_pkg::*;

    localparam int STACK_DEPTH    = 32;
    localparam int NUM_VARS       = 26;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int PHASE_ITEMS    = 250;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 100;
    localparam logic [3:0] FN_UNUSED_LO = 4'd12;
    localparam logic [3:0] FN_UNUSED_HI = 4'd15;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    cmd_t        cmd = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    int          errors;
    int          rsp_count;
    int          sent = 0;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    always #2 clk = ~clk;

    basic_il_expression_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_VARS    (NUM_VARS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    expr_stack_checker #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_VARS    (NUM_VARS)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .errors    (errors),
        .rsp_count (rsp_count)
    );

    // Response back-pressure: a requested hold-off wins over random stalls
    always @(posedge clk)
    begin
        if (hold_reqs != hold_served)
        begin
            hold_served <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // One command transfer, after a random gap
    task automatic send_cmd(input logic [3:0] f, input logic [31:0] v);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= cmd_t'{f, v};
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic push_value(input logic [31:0] v);
        send_cmd(FN_PUSH, v);
    endtask

    // Operand mix: extremes, small numbers and full-range patterns
    function automatic logic [31:0] rand_val();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'($urandom_range(200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_idx();
        case ($urandom_range(9))
            0:       return 32'(NUM_VARS);
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return 32'($urandom_range(NUM_VARS - 1));
        endcase
    endfunction

    function automatic logic [31:0] rand_rel();
        case ($urandom_range(19))
            0:       return 32'd6;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return 32'($urandom_range(5));
        endcase
    endfunction

    initial
    begin
        int unsigned base;
        int unsigned pick;
        logic [31:0] a;
        logic        held;
        held = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: underflow, wraparound, division corners, variables, compare
        send_cmd(FN_POP, 32'hFFFF_FFFF);        // pop on an empty stack
        push_value(32'h7FFF_FFFF);
        send_cmd(FN_ADD, '0);                   // only one operand
        push_value(32'd1);
        send_cmd(FN_ADD, '0);                   // wraps to most negative
        send_cmd(FN_NEG, '0);                   // negating most negative wraps
        push_value(32'hFFFF_FFFF);
        send_cmd(FN_DIV, '0);                   // most negative over -1
        push_value(32'd0);
        send_cmd(FN_DIV, '0);                   // zero divisor, stack untouched
        send_cmd(FN_MUL, '0);
        push_value(32'hFFFF_FFF9);
        send_cmd(FN_SUB, '0);
        push_value(32'd2);
        send_cmd(FN_DIV, '0);                   // truncation toward zero
        push_value(32'(NUM_VARS - 1));
        push_value(32'h1234_5678);
        send_cmd(FN_STORE, '0);
        push_value(32'(NUM_VARS - 1));
        send_cmd(FN_INDEX, '0);
        push_value(32'(NUM_VARS));
        send_cmd(FN_INDEX, '0);                 // index past the store
        push_value(32'd6);
        push_value(32'd3);
        send_cmd(FN_CMP, '0);                   // bad relation code
        send_cmd(FN_CLRV, '0);
        send_cmd(FN_UNUSED_LO, 32'hFFFF_FFFF);
        send_cmd(FN_UNUSED_HI, '0);
        send_cmd(FN_CLRS, '0);

        // Random: mostly well-formed sequences, some noise
        base = sent;
        while (sent < base + RANDOM_ITEMS)
        begin
            case ((sent - base) / PHASE_ITEMS)
                0:
                begin
                    snd_idle_pct = 0;
                    rcv_stall_pct <= 0;
                end
                1:
                begin
                    snd_idle_pct = 80;
                    rcv_stall_pct <= 0;
                end
                2:
                begin
                    snd_idle_pct = 0;
                    rcv_stall_pct <= 80;
                end
                default:
                begin
                    snd_idle_pct = 29;
                    rcv_stall_pct <= 29;
                end
            endcase
            // long receiver hold-off while commands keep coming
            if (!held && sent - base >= 100)
            begin
                hold_reqs <= hold_reqs + 1;
                held = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                push_value(rand_val());
                push_value(rand_val());
                case ($urandom_range(3))
                    0:       send_cmd(FN_ADD, $urandom);
                    1:       send_cmd(FN_SUB, $urandom);
                    2:       send_cmd(FN_MUL, $urandom);
                    default: send_cmd(FN_DIV, $urandom);
                endcase
            end
            else if (pick < 35)
            begin
                push_value(rand_val());
                send_cmd(FN_NEG, $urandom);
            end
            else if (pick < 50)
            begin
                push_value(rand_idx());
                push_value(rand_val());
                send_cmd(FN_STORE, $urandom);
            end
            else if (pick < 60)
            begin
                push_value(rand_idx());
                send_cmd(FN_INDEX, $urandom);
            end
            else if (pick < 75)
            begin
                a = rand_val();
                push_value(a);
                push_value(rand_rel());
                push_value(($urandom_range(3) == 0) ? a : rand_val());
                send_cmd(FN_CMP, $urandom);
            end
            else if (pick < 80)
                send_cmd(FN_POP, $urandom);
            else if (pick < 85)
                send_cmd(FN_CLRS, $urandom);
            else if (pick < 87)
                send_cmd(FN_CLRV, $urandom);
            else if (pick < 89)
            begin
                // fill past the top to reach overflow
                repeat (STACK_DEPTH + 2)
                    push_value(rand_val());
                send_cmd(FN_CLRS, $urandom);
            end
            else
                send_cmd(4'($urandom_range(15)), $urandom);
        end
        cmd_valid <= 1'b0;
        rcv_stall_pct <= 0;

        // Drain, then a quiet tail to catch stray responses
        while (rsp_count < sent)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/biles_pkg.sv
rtl/biles_stack_mem.sv
rtl/biles_var_mem.sv
rtl/biles_muldiv.sv
rtl/basic_il_expression_stack.sv
tb/expr_stack_checker.sv
tb/testbench.sv
